>>> src/rmq_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared widths, types and helpers for the matrix to quaternion pipeline.
// ---------------------------------------------------------------------------
package rmq_pkg;

	localparam int DW      = 16;
	localparam int FRAC    = DW - 2;
	// radicand: V (up to DW+2 bits, non-negative) shifted by FRAC
	localparam int RADW    = DW + 2 + FRAC;
	localparam int ROOTW   = (RADW + 1) / 2;
	// numerator: sum/diff of two entries, DW+1 bits, times 2^FRAC
	localparam int NUMW    = DW + 1 + FRAC;
	localparam int DENW    = ROOTW + 1;
	localparam int QUOW    = NUMW;
	localparam int SQ_STEPS  = ROOTW;
	localparam int DIV_STEPS = QUOW;

	typedef logic signed [DW-1:0] data_t;

	// per item control that travels alongside the datapath
	typedef struct packed {
		logic       trace;   // trace branch taken
		logic [1:0] sel;     // diagonal index for the other branch
	} ctl_t;

	function automatic data_t sat_fn(input logic signed [NUMW:0] v);
		logic signed [NUMW:0] hi;
		logic signed [NUMW:0] lo;
		begin
			hi = (NUMW+1)'((64'sd1 <<< (DW-1)) - 1);
			lo = -hi - 1;
			if (v > hi) sat_fn = data_t'(hi);
			else if (v < lo) sat_fn = data_t'(lo);
			else sat_fn = data_t'(v);
		end
	endfunction

endpackage

>>> src/rmq_sqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmq_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module rmq_sqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [rmq_pkg::RADW-1:0]   rad,
	output logic [rmq_pkg::ROOTW-1:0]  root
);
	import rmq_pkg::*;

	localparam int RW = ROOTW + 2;

	logic [RADW-1:0]  rad_s  [SQ_STEPS+1];
	logic [RW-1:0]    rem_s  [SQ_STEPS+1];
	logic [ROOTW-1:0] res_s  [SQ_STEPS+1];

	// radicand padded to an even width for pairs of bits
	localparam int PW = 2 * ROOTW;
	logic [PW-1:0] rad_pad;
	assign rad_pad = PW'(rad);

	always_comb begin
		rad_s[0] = RADW'(rad_pad);
		rem_s[0] = '0;
		res_s[0] = '0;
	end

	genvar g;
	generate
		for (g = 0; g < SQ_STEPS; g++) begin : g_st
			logic [PW-1:0] pad;
			logic [RW-1:0] trial;
			logic [RW-1:0] cur;
			logic [RW-1:0] nrem;
			logic [ROOTW-1:0] nres;
			logic [RADW-1:0] srad;
			always_comb begin
				pad   = PW'(rad_s[g]);
				cur   = RW'({rem_s[g], pad[PW-1-2*g -: 2]});
				trial = RW'({res_s[g], 2'b01});
				if (cur >= trial) begin
					nrem = cur - trial;
					nres = ROOTW'({res_s[g], 1'b1});
				end else begin
					nrem = cur;
					nres = ROOTW'({res_s[g], 1'b0});
				end
				srad = rad_s[g];
			end
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[g+1] <= srad;
					rem_s[g+1] <= nrem;
					res_s[g+1] <= nres;
				end
			end
		end
	endgenerate

	assign root = res_s[SQ_STEPS];

endmodule

>>> src/rmq_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmq_div
// Pipelined signed divider, one quotient bit per stage, truncating toward 0.
// ---------------------------------------------------------------------------
module rmq_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [rmq_pkg::DW:0]   num,
	input  logic [rmq_pkg::DENW-1:0]      den,
	output logic signed [rmq_pkg::NUMW:0] quo
);
	import rmq_pkg::*;

	localparam int RW = DENW + 1;

	logic [NUMW-1:0] n_s   [DIV_STEPS+1];
	logic [DENW-1:0] d_s   [DIV_STEPS+1];
	logic [RW-1:0]   r_s   [DIV_STEPS+1];
	logic            neg_s [DIV_STEPS+1];

	logic [DW:0] mag;
	always_comb begin
		mag = num[DW] ? (DW+1)'(-num) : (DW+1)'(num);
		n_s[0]   = {mag, FRAC'(0)};
		d_s[0]   = (den == '0) ? DENW'(1) : den;
		r_s[0]   = '0;
		neg_s[0] = num[DW];
	end

	genvar g;
	generate
		for (g = 0; g < DIV_STEPS; g++) begin : g_st
			logic [RW-1:0]   cur;
			logic [NUMW-1:0] nn;
			logic [RW-1:0]   nr;
			always_comb begin
				cur = RW'({r_s[g][RW-2:0], n_s[g][NUMW-1]});
				nn  = {n_s[g][NUMW-2:0], 1'b0};
				if (cur >= RW'(d_s[g])) begin
					nr = cur - RW'(d_s[g]);
					nn[0] = 1'b1;
				end else begin
					nr = cur;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					n_s[g+1]   <= nn;
					d_s[g+1]   <= d_s[g];
					r_s[g+1]   <= nr;
					neg_s[g+1] <= neg_s[g];
				end
			end
		end
	endgenerate

	always_comb begin
		if (neg_s[DIV_STEPS]) quo = -$signed({1'b0, n_s[DIV_STEPS]});
		else quo = $signed({1'b0, n_s[DIV_STEPS]});
	end

endmodule

>>> src/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a 3x3 rotation matrix to a unit quaternion.
// ---------------------------------------------------------------------------
// One matrix item is accepted per cycle while in_stall is low, and one
// quaternion item comes out per item, in order. The pipe holds the stage 1
// register, 16 square root stages, 31 divider stages and an output register;
// it advances together whenever the output register is free, so the rate is
// one item per cycle with no bubbles unless out_stall holds a valid output.
// Entries and results are signed Q1.14. When the trace plus one exceeds one,
// w comes from the root of the trace plus one; otherwise the first strictly
// largest diagonal entry picks the component built from the root. Divisors
// of zero are forced to one LSB, results saturate.
module rotation_matrix_to_quaternion (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  rmq_pkg::data_t m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic           out_valid,
	input  logic           out_stall,
	output rmq_pkg::data_t qx, qy, qz, qw
);
	import rmq_pkg::*;

	localparam int LAT = SQ_STEPS + DIV_STEPS + 2;

	// whole pipe moves when the output register can take data
	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	logic [LAT-1:0] vld_q;

	// ---- stage 1: branch decision, radicand and three numerators --------
	logic signed [DW+2:0] t_c, v_c;
	logic signed [DW:0]   d12, d20, d01, s01, s02, s12;
	ctl_t ctl_c;
	always_comb begin
		d12 = (DW+1)'(m12) - (DW+1)'(m21);
		d20 = (DW+1)'(m20) - (DW+1)'(m02);
		d01 = (DW+1)'(m01) - (DW+1)'(m10);
		s01 = (DW+1)'(m01) + (DW+1)'(m10);
		s02 = (DW+1)'(m02) + (DW+1)'(m20);
		s12 = (DW+1)'(m12) + (DW+1)'(m21);
		t_c = (DW+3)'(1 <<< FRAC) + (DW+3)'(m00) + (DW+3)'(m11) + (DW+3)'(m22);
		ctl_c.trace = t_c > (DW+3)'(1 <<< FRAC);
		ctl_c.sel = 2'd0;
		if (m11 > m00) ctl_c.sel = 2'd1;
		if (m22 > ((m11 > m00) ? m11 : m00)) ctl_c.sel = 2'd2;
		if (ctl_c.trace) v_c = t_c;
		else begin
			case (ctl_c.sel)
				2'd0: v_c = (DW+3)'(1 <<< FRAC) + m00 - m11 - m22;
				2'd1: v_c = (DW+3)'(1 <<< FRAC) + m11 - m00 - m22;
				default: v_c = (DW+3)'(1 <<< FRAC) + m22 - m00 - m11;
			endcase
		end
	end

	logic [RADW-1:0]   rad_s1;
	ctl_t              ctl_s1;
	logic signed [DW:0] na_s1, nb_s1, nc_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= v_c[DW+2] ? '0 : RADW'({v_c[DW+1:0], FRAC'(0)});
			ctl_s1 <= ctl_c;
			if (ctl_c.trace) begin
				na_s1 <= d12; nb_s1 <= d20; nc_s1 <= d01;
			end else begin
				case (ctl_c.sel)
					2'd0: begin na_s1 <= s01; nb_s1 <= s02; nc_s1 <= d12; end
					2'd1: begin na_s1 <= s01; nb_s1 <= s12; nc_s1 <= d20; end
					default: begin na_s1 <= s02; nb_s1 <= s12; nc_s1 <= d01; end
				endcase
			end
		end
	end

	// ---- square root stages, side data delayed alongside ----------------
	logic [ROOTW-1:0] root;
	rmq_sqrt u_sqrt (.clk, .en, .rad(rad_s1), .root);

	ctl_t               ctl_d [SQ_STEPS];
	logic signed [DW:0] na_d [SQ_STEPS], nb_d [SQ_STEPS], nc_d [SQ_STEPS];
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_d[0] <= ctl_s1; na_d[0] <= na_s1; nb_d[0] <= nb_s1; nc_d[0] <= nc_s1;
			for (int k = 1; k < SQ_STEPS; k++) begin
				ctl_d[k] <= ctl_d[k-1]; na_d[k] <= na_d[k-1];
				nb_d[k] <= nb_d[k-1]; nc_d[k] <= nc_d[k-1];
			end
		end
	end

	// ---- dividers: 2r in both branches -----------------------------------
	logic [DENW-1:0] den;
	assign den = {root, 1'b0};
	logic signed [NUMW:0] qa, qb, qc;
	rmq_div u_div_a (.clk, .en, .num(na_d[SQ_STEPS-1]), .den, .quo(qa));
	rmq_div u_div_b (.clk, .en, .num(nb_d[SQ_STEPS-1]), .den, .quo(qb));
	rmq_div u_div_c (.clk, .en, .num(nc_d[SQ_STEPS-1]), .den, .quo(qc));

	// root component: r/2 in both branches (2r >> 2 == r >> 1)
	ctl_t             ctl_e [DIV_STEPS];
	logic [ROOTW-1:0] rt_e  [DIV_STEPS];
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_e[0] <= ctl_d[SQ_STEPS-1]; rt_e[0] <= root;
			for (int k = 1; k < DIV_STEPS; k++) begin
				ctl_e[k] <= ctl_e[k-1]; rt_e[k] <= rt_e[k-1];
			end
		end
	end

	// ---- output register ---------------------------------------------------
	data_t sa, sb, sc, sr;
	always_comb begin
		sa = sat_fn(qa);
		sb = sat_fn(qb);
		sc = sat_fn(qc);
		sr = data_t'(rt_e[DIV_STEPS-1] >> 1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_e[DIV_STEPS-1].trace) begin
				qx <= sa; qy <= sb; qz <= sc; qw <= sr;
			end else begin
				case (ctl_e[DIV_STEPS-1].sel)
					2'd0: begin qx <= sr; qy <= sa; qz <= sb; qw <= sc; end
					2'd1: begin qx <= sa; qy <= sr; qz <= sb; qw <= sc; end
					default: begin qx <= sa; qy <= sb; qz <= sr; qw <= sc; end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[LAT-1];

endmodule
